// ===== rtl/core/three_way_merge_step_assert.svh =====
// ---------------------------------------------------------------------------
// three-way merge step: assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge and
// switched off while the synchronous active-low reset is held
// ---------------------------------------------------------------------------
`ifndef THREE_WAY_MERGE_STEP_ASSERT_SVH
`define THREE_WAY_MERGE_STEP_ASSERT_SVH

// same-cycle implication
`define TWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/twm_pkg.sv =====
// ---------------------------------------------------------------------------
// twm_pkg
// types, sizes and helper functions of the three-way merge step
// ---------------------------------------------------------------------------
package twm_pkg;

    // field width on the channels
    localparam int FIELD_W    = 64;
    // significant key and value bits inside the fields
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;

    localparam int KeyShift = FIELD_W - KEY_BITS;
    localparam logic [FIELD_W-1:0] ValMask = {FIELD_W{1'b1}} >> (FIELD_W - VALUE_BITS);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic                      anc_present;
        logic signed [FIELD_W-1:0] anc_key;
        logic        [FIELD_W-1:0] anc_value;
        logic                      ours_present;
        logic signed [FIELD_W-1:0] ours_key;
        logic        [FIELD_W-1:0] ours_value;
        logic                      theirs_present;
        logic signed [FIELD_W-1:0] theirs_key;
        logic        [FIELD_W-1:0] theirs_value;
    } t_in_item;

    typedef struct packed {
        logic                      emit;
        logic signed [FIELD_W-1:0] out_key;
        logic        [FIELD_W-1:0] out_value;
        logic                      advance_anc;
        logic                      advance_ours;
        logic                      advance_theirs;
        t_status                   status;
    } t_out_item;

    // sides holding the smallest key
    typedef struct packed {
        logic anc;
        logic ours;
        logic theirs;
    } t_hits;

    // minimum search result handed to the resolver
    typedef struct packed {
        logic                      found;
        logic signed [FIELD_W-1:0] kmin;
        t_hits                     hits;
    } t_min_res;

    // sign-extend the low KEY_BITS of a key field
    function automatic logic signed [FIELD_W-1:0] key_ext(input logic [FIELD_W-1:0] raw);
        logic signed [FIELD_W-1:0] sh;
        sh = signed'(raw << KeyShift);
        return sh >>> KeyShift;
    endfunction

    // keep the low VALUE_BITS of a value field
    function automatic logic [FIELD_W-1:0] val_mask(input logic [FIELD_W-1:0] raw);
        return raw & ValMask;
    endfunction

endpackage

// ===== rtl/core/twm_if.sv =====
// ---------------------------------------------------------------------------
// twm_if
// valid/ready channels carrying merge heads in and merge results out
// ---------------------------------------------------------------------------
interface twm_in_if;
    logic               valid;
    logic               ready;
    twm_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface twm_out_if;
    logic               valid;
    logic               ready;
    twm_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/three_way_merge_step.sv =====
// ---------------------------------------------------------------------------
// three_way_merge_step
// one step of a three-way merge over sorted ancestor/ours/theirs streams
// ---------------------------------------------------------------------------
// usage
//   i_in carries one transaction per step: the head of each stream (present
//   flag, signed key, value word). o_out returns exactly one transaction per
//   input: the smallest key, which sides hold it, whether a merged row is
//   emitted with its value, and a status of ok, conflict or no stream.
//   path: an input taken is held in the input register, resolved by the
//   comparators and the resolution table, and then captured in the result
//   register, from which the receiver takes it.
//   throughput: one transaction per cycle unless the receiver stalls, set
//   by the single register stage on each side of the compare and table logic.
//   a stalled receiver holds the result register; the input register keeps
//   filling, and i_in.ready drops only once both stages hold transactions.
//   reset (synchronous, active low) empties both stages; nothing is held
//   across transactions, so the block starts clean.
// ---------------------------------------------------------------------------
`include "three_way_merge_step_assert.svh"

module three_way_merge_step (
    input logic        i_clk,
    input logic        i_rst_n,
    twm_in_if.sink     i_in,
    twm_out_if.source  o_out
);
    import twm_pkg::*;

    // input stage
    logic      r_s1_valid, n_s1_valid;
    t_in_item  r_s1_item;
    // result stage
    logic      r_s2_valid, n_s2_valid;
    t_out_item r_s2_res;

    t_min_res  min_res;
    t_out_item res;
    logic      s2_load;
    logic      s1_load;

    // result stage can take a new transaction when empty or being drained
    assign s2_load = !r_s2_valid || o_out.ready;
    // input stage frees up when empty or moving on
    assign i_in.ready = !r_s1_valid || s2_load;
    assign s1_load    = i_in.valid && i_in.ready;

    twm_min_find u_min_find (
        .i_item (r_s1_item),
        .o_min  (min_res)
    );

    twm_resolve u_resolve (
        .i_item (r_s1_item),
        .i_min  (min_res),
        .o_res  (res)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_in.ready) begin
            n_s1_valid = i_in.valid;
        end
        n_s2_valid = r_s2_valid;
        if (s2_load) begin
            n_s2_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_item <= i_in.payload;
        end
        if (s2_load && r_s1_valid) begin
            r_s2_res <= res;
        end
    end

    assign o_out.valid   = r_s2_valid;
    assign o_out.payload = r_s2_res;

    // a row is only emitted on a clean resolution
    `TWM_ASSERT_NOW(a_emit_ok, i_clk, i_rst_n,
        o_out.valid && o_out.payload.emit, o_out.payload.status == ST_OK,
        "emitted row without ok status")

    // no stream present leaves nothing to advance and no key
    `TWM_ASSERT_NOW(a_empty_clean, i_clk, i_rst_n,
        o_out.valid && o_out.payload.status == ST_EMPTY,
        !o_out.payload.emit && o_out.payload.out_key == '0 &&
        !o_out.payload.advance_anc && !o_out.payload.advance_ours &&
        !o_out.payload.advance_theirs,
        "empty step with row, key or advance set")

    // a conflict needs at least two sides on the key and never emits
    `TWM_ASSERT_NOW(a_conflict_sides, i_clk, i_rst_n,
        o_out.valid && o_out.payload.status == ST_CONFLICT,
        !o_out.payload.emit && $countones({o_out.payload.advance_anc,
        o_out.payload.advance_ours, o_out.payload.advance_theirs}) >= 2,
        "conflict with fewer than two sides or with a row")

    // a filled input stage moving on always lands in the result stage
    `TWM_ASSERT_NEXT(a_stage_move, i_clk, i_rst_n,
        r_s1_valid && s2_load, o_out.valid,
        "input stage transaction lost on the way to the result stage")

endmodule

// ===== rtl/core/twm_min_find.sv =====
// ---------------------------------------------------------------------------
// twm_min_find
// smallest present key among the three heads and the sides that hold it
// ---------------------------------------------------------------------------
module twm_min_find (
    input  twm_pkg::t_in_item i_item,
    output twm_pkg::t_min_res o_min
);
    import twm_pkg::*;

    logic signed [FIELD_W-1:0] ka, ko, kt;
    logic                      pa, po, pt;
    logic                      sel_a, sel_o, sel_t;

    assign pa = i_item.anc_present;
    assign po = i_item.ours_present;
    assign pt = i_item.theirs_present;
    assign ka = key_ext(i_item.anc_key);
    assign ko = key_ext(i_item.ours_key);
    assign kt = key_ext(i_item.theirs_key);

    // a side is a minimum holder when present and not above any other present key
    assign sel_a = pa && (!po || ka <= ko) && (!pt || ka <= kt);
    assign sel_o = po && (!pa || ko <= ka) && (!pt || ko <= kt);
    assign sel_t = pt && (!pa || kt <= ka) && (!po || kt <= ko);

    always_comb begin
        o_min.found       = pa || po || pt;
        o_min.hits.anc    = sel_a;
        o_min.hits.ours   = sel_o;
        o_min.hits.theirs = sel_t;
        if (sel_a) begin
            o_min.kmin = ka;
        end else if (sel_o) begin
            o_min.kmin = ko;
        end else if (sel_t) begin
            o_min.kmin = kt;
        end else begin
            o_min.kmin = '0;
        end
    end

endmodule

// ===== rtl/core/twm_resolve.sv =====
// ---------------------------------------------------------------------------
// twm_resolve
// resolution table over the sides holding the smallest key
// ---------------------------------------------------------------------------
module twm_resolve (
    input  twm_pkg::t_in_item  i_item,
    input  twm_pkg::t_min_res  i_min,
    output twm_pkg::t_out_item o_res
);
    import twm_pkg::*;

    logic [FIELD_W-1:0] va, vo, vt;
    logic               eq_oa, eq_ta, eq_ot;
    logic               a, o, t;
    logic               emit;
    logic [FIELD_W-1:0] ov;
    t_status            st;

    assign va = val_mask(i_item.anc_value);
    assign vo = val_mask(i_item.ours_value);
    assign vt = val_mask(i_item.theirs_value);
    assign eq_oa = (vo == va);
    assign eq_ta = (vt == va);
    assign eq_ot = (vo == vt);
    assign a = i_min.hits.anc;
    assign o = i_min.hits.ours;
    assign t = i_min.hits.theirs;

    always_comb begin
        emit = 1'b0;
        ov   = '0;
        st   = ST_OK;
        if (!i_min.found) begin
            st = ST_EMPTY;
        end else if (a && o && t) begin
            if (eq_oa && eq_ta) begin
                emit = 1'b1;
                ov   = va;
            end else if (eq_oa) begin
                emit = 1'b1;
                ov   = vt;
            end else if (eq_ta) begin
                emit = 1'b1;
                ov   = vo;
            end else if (eq_ot) begin
                emit = 1'b1;
                ov   = vo;
            end else begin
                st = ST_CONFLICT;
            end
        end else if (a && o) begin
            // deleted by theirs unless ours changed it
            if (!eq_oa) begin
                st = ST_CONFLICT;
            end
        end else if (a && t) begin
            if (!eq_ta) begin
                st = ST_CONFLICT;
            end
        end else if (a) begin
            // deleted on both sides
        end else if (o && t) begin
            if (eq_ot) begin
                emit = 1'b1;
                ov   = vo;
            end else begin
                st = ST_CONFLICT;
            end
        end else if (o) begin
            emit = 1'b1;
            ov   = vo;
        end else begin
            emit = 1'b1;
            ov   = vt;
        end

        o_res.emit           = emit;
        o_res.out_key        = i_min.kmin;
        o_res.out_value      = ov;
        o_res.advance_anc    = a;
        o_res.advance_ours   = o;
        o_res.advance_theirs = t;
        o_res.status         = st;
    end

endmodule
